>>> sv/splim_pkg.sv
// Shared types and constants for the speed profile acceleration limiter.
`timescale 1ns / 1ps

package splim_pkg;

    localparam int SPEED_FRAC_BITS = 8;
    localparam int LIMIT_FRAC      = 8;
    localparam int POS_FRAC        = 16;

    localparam int SPD_W  = 16;
    localparam int POS_W  = 32;
    localparam int LIM_W  = 16;
    localparam int PROD_W = LIM_W + 1 + POS_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SQ_W   = 31;
    localparam int RAD_W  = 30;
    localparam int ROOT_W = 15;

    localparam int LIN_SHIFT = LIMIT_FRAC + POS_FRAC - SPEED_FRAC_BITS;
    localparam int SQ_SHIFT  = LIMIT_FRAC + POS_FRAC - 2 * SPEED_FRAC_BITS;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_BY_DISTANCE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL_LIMIT       = 8'd2;

    localparam logic [LIM_W-1:0] ACCEL_RESET = 16'd256;
    localparam logic [LIM_W-1:0] DECEL_RESET = 16'd256;

    typedef enum logic [1:0] {
        CLS_PASS,
        CLS_UP,
        CLS_DOWN,
        CLS_EQUAL
    } cls_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_MUL,
        BS_BOUND,
        BS_SQRT,
        BS_DONE
    } bst_t;

    typedef struct packed {
        logic             limit_by_distance;
        logic [LIM_W-1:0] accel_max;
        logic [LIM_W-1:0] decel_max;
    } cfg_t;

    typedef struct packed {
        cls_t             cls;
        logic             by_dist;
        logic [SPD_W-1:0] cur;
        logic [SPD_W-1:0] prev;
        logic             dneg;
        logic [POS_W-1:0] dmag;
        logic [LIM_W-1:0] lim;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] radicand;
    } sq_req_t;

    typedef struct packed {
        logic              busy;
        logic [ROOT_W-1:0] root;
    } sq_rsp_t;

endpackage

>>> sv/splim_front.sv
// Front end: accepts points, computes the position delta and classifies the speed change.
`timescale 1ns / 1ps

module splim_front
    import splim_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [POS_W-1:0] position,
    input  logic [SPD_W-1:0] speed,
    input  logic             first_of_profile,
    input  q_stat_t          q_stat,
    output logic             q_push,
    output job_t             q_data
);

    logic [POS_W-1:0] prev_position_reg;
    logic [SPD_W-1:0] prev_speed_reg;
    logic [POS_W:0]   delta;
    logic [POS_W:0]   delta_neg;
    cls_t             cls;

    assign in_ready  = !q_stat.full;
    assign q_push    = in_valid && !q_stat.full;
    assign delta     = {1'b0, position} - {1'b0, prev_position_reg};
    assign delta_neg = -delta;

    always_comb
    begin
        priority if (first_of_profile)
        begin
            cls = CLS_PASS;
        end
        else if ($signed(speed) > $signed(prev_speed_reg))
        begin
            cls = CLS_UP;
        end
        else if ($signed(speed) < $signed(prev_speed_reg))
        begin
            cls = CLS_DOWN;
        end
        else
        begin
            cls = CLS_EQUAL;
        end
    end

    always_comb
    begin
        q_data.cls     = cls;
        q_data.by_dist = cfg.limit_by_distance;
        q_data.cur     = speed;
        q_data.prev    = prev_speed_reg;
        q_data.dneg    = delta[POS_W];
        q_data.dmag    = delta[POS_W] ? delta_neg[POS_W-1:0] : delta[POS_W-1:0];
        q_data.lim     = (cls == CLS_UP) ? cfg.accel_max : cfg.decel_max;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_position_reg <= '0;
            prev_speed_reg    <= '0;
        end
        else if (q_push)
        begin
            prev_position_reg <= position;
            prev_speed_reg    <= speed;
        end
    end

endmodule

>>> sv/splim_fifo.sv
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module splim_fifo
    import splim_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    wdata,
    input  logic    pop,
    output job_t    rdata,
    output q_stat_t stat
);

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign stat.full  = (count_reg == (QPTR_W + 1)'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign rdata      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

>>> sv/splim_sqrt.sv
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps

module splim_sqrt
    import splim_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  sq_req_t req,
    output sq_rsp_t rsp
);

    logic             busy_reg;
    logic [RAD_W-1:0] rem_reg;
    logic [RAD_W-1:0] res_reg;
    logic [RAD_W-1:0] bit_reg;
    logic [RAD_W:0]   trial;
    logic             take;

    assign trial    = {1'b0, res_reg} + {1'b0, bit_reg};
    assign take     = ({1'b0, rem_reg} >= trial);
    assign rsp.busy = busy_reg;
    assign rsp.root = res_reg[ROOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && bit_reg[0])
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.radicand;
            res_reg <= '0;
            bit_reg <= RAD_W'(1) << (RAD_W - 2);
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                rem_reg <= rem_reg - trial[RAD_W-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

>>> sv/splim_back.sv
// Back end: computes the speed bound for each queued speed-up or slow-down job and selects the result.
`timescale 1ns / 1ps

module splim_back
    import splim_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  job_t             q_data,
    input  q_stat_t          q_stat,
    output logic             q_pop,
    output sq_req_t          sq_req,
    input  sq_rsp_t          sq_rsp,
    output logic             res_valid,
    input  logic             res_ready,
    output logic [SPD_W-1:0] res_speed,
    output logic             res_clipped
);

    localparam logic signed [SUM_W-1:0] LIN_MAX = 32767;
    localparam logic signed [SUM_W-1:0] LIN_MIN = -32768;

    bst_t                     state_reg;
    bst_t                     state_next;
    job_t                     job_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [SPD_W-1:0]         bound_reg;
    logic [SPD_W-1:0]         bound_next;

    logic [LIM_W:0]           lim_eff;
    logic [31:0]              prev32;
    logic [31:0]              sq_full;
    logic [PROD_W-1:0]        step;
    logic signed [SUM_W-1:0]  step_s;
    logic signed [SUM_W-1:0]  step_eff;
    logic signed [SUM_W-1:0]  prev_ext;
    logic signed [SUM_W-1:0]  sq_ext;
    logic signed [SUM_W-1:0]  lin_sum;
    logic signed [SUM_W-1:0]  rad;
    logic                     rad_pos;
    logic                     rad_big;
    logic                     need_sqrt;
    logic                     skip_math;

    // multiply stage operands
    assign lim_eff = job_reg.by_dist ? {job_reg.lim, 1'b0} : {1'b0, job_reg.lim};
    assign prev32  = {{(32 - SPD_W){job_reg.prev[SPD_W-1]}}, job_reg.prev};
    assign sq_full = prev32 * prev32;

    // bound stage
    assign step     = job_reg.by_dist ? (prod_reg >> SQ_SHIFT) : (prod_reg >> LIN_SHIFT);
    assign step_s   = job_reg.dneg ? -$signed({2'b00, step}) : $signed({2'b00, step});
    assign step_eff = (job_reg.cls == CLS_UP) ? step_s : -step_s;
    assign prev_ext = $signed({{(SUM_W - SPD_W){job_reg.prev[SPD_W-1]}}, job_reg.prev});
    assign sq_ext   = $signed({{(SUM_W - SQ_W){1'b0}}, sq_reg});
    assign lin_sum  = prev_ext + step_eff;
    assign rad      = sq_ext + step_eff;
    assign rad_pos  = !rad[SUM_W-1] && (rad != '0);
    assign rad_big  = |rad[SUM_W-2:RAD_W];
    assign need_sqrt = job_reg.by_dist && rad_pos && !rad_big;
    assign skip_math = (q_data.cls == CLS_PASS) || (q_data.cls == CLS_EQUAL);

    always_comb
    begin
        if (!job_reg.by_dist)
        begin
            if (lin_sum > LIN_MAX)
            begin
                bound_next = 16'h7fff;
            end
            else if (lin_sum < LIN_MIN)
            begin
                bound_next = 16'h8000;
            end
            else
            begin
                bound_next = lin_sum[SPD_W-1:0];
            end
        end
        else if (!rad_pos)
        begin
            bound_next = '0;
        end
        else
        begin
            bound_next = 16'h7fff;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = skip_math ? BS_DONE : BS_MUL;
                end
            end
            BS_MUL:
            begin
                state_next = BS_BOUND;
            end
            BS_BOUND:
            begin
                state_next = need_sqrt ? BS_SQRT : BS_DONE;
            end
            BS_SQRT:
            begin
                if (!sq_rsp.busy)
                begin
                    state_next = BS_DONE;
                end
            end
            BS_DONE:
            begin
                if (res_ready)
                begin
                    state_next = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop           = (state_reg == BS_IDLE) && !q_stat.empty;
        sq_req.start    = (state_reg == BS_BOUND) && need_sqrt;
        sq_req.radicand = rad[RAD_W-1:0];
        res_valid       = (state_reg == BS_DONE);
    end

    always_comb
    begin
        unique case (job_reg.cls)
            CLS_PASS:
            begin
                res_speed = job_reg.cur;
            end
            CLS_UP:
            begin
                res_speed = ($signed(bound_reg) < $signed(job_reg.cur)) ? bound_reg : job_reg.cur;
            end
            CLS_DOWN:
            begin
                res_speed = ($signed(bound_reg) > $signed(job_reg.cur)) ? bound_reg : job_reg.cur;
            end
            CLS_EQUAL:
            begin
                res_speed = job_reg.cur[SPD_W-1] ? '0 : job_reg.cur;
            end
            default:
            begin
                res_speed = job_reg.cur;
            end
        endcase
        res_clipped = (res_speed != job_reg.cur);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_data;
        end
        if (state_reg == BS_MUL)
        begin
            prod_reg <= PROD_W'(lim_eff) * PROD_W'(job_reg.dmag);
            sq_reg   <= sq_full[SQ_W-1:0];
        end
        if (state_reg == BS_BOUND)
        begin
            bound_reg <= bound_next;
        end
        if ((state_reg == BS_SQRT) && !sq_rsp.busy)
        begin
            bound_reg <= {1'b0, sq_rsp.root};
        end
    end

endmodule

>>> sv/speed_profile_accel_limiter_top.sv
// Top level of the speed profile acceleration limiter.
`timescale 1ns / 1ps
//
// Points (position, speed, first_of_profile) enter on the in_valid/in_ready
// channel; one result (limited_speed, was_clipped) leaves per point on the
// out_valid/out_ready channel, in order. Registers are written through the
// cfg_valid/cfg_ready channel (always ready): index 0 limit_by_distance,
// 1 accel limit, 2 decel limit; other indexes are ignored. Write only idle.
// The front end pushes each accepted point into a two-entry queue; the back
// end works one job at a time. First-of-profile and equal-speed points go
// straight to select; time-mode points pass multiply, bound and select;
// distance-mode points add the bit-serial square root (15 iterations over a
// 30-bit radicand) after bound when the radicand is positive and fits.
// A full output register holds the back end in its result state while
// out_ready is low; the queue keeps taking points until full. Reset clears
// the previous point to position 0, speed 0, the queue, the pipeline and
// sets the limits to 1.0 and the mode to time.
//

module speed_profile_accel_limiter_top
    import splim_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [POS_W-1:0]      position,
    input  logic [SPD_W-1:0]      speed,
    input  logic                  first_of_profile,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SPD_W-1:0]      limited_speed,
    output logic                  was_clipped
);

    cfg_t             cfg_reg;
    logic             out_valid_reg;
    logic [SPD_W-1:0] limited_speed_reg;
    logic             was_clipped_reg;

    logic             q_push;
    logic             q_pop;
    job_t             q_wdata;
    job_t             q_rdata;
    q_stat_t          q_stat;
    sq_req_t          sq_req;
    sq_rsp_t          sq_rsp;
    logic             res_valid;
    logic             res_ready;
    logic [SPD_W-1:0] res_speed;
    logic             res_clipped;

    assign cfg_ready     = 1'b1;
    assign res_ready     = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign limited_speed = limited_speed_reg;
    assign was_clipped   = was_clipped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.limit_by_distance <= 1'b0;
            cfg_reg.accel_max         <= ACCEL_RESET;
            cfg_reg.decel_max         <= DECEL_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_LIMIT_BY_DISTANCE)
            begin
                cfg_reg.limit_by_distance <= cfg_data[0];
            end
            else if (cfg_index == REG_ACCEL_LIMIT)
            begin
                cfg_reg.accel_max <= cfg_data[LIM_W-1:0];
            end
            else if (cfg_index == REG_DECEL_LIMIT)
            begin
                cfg_reg.decel_max <= cfg_data[LIM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            limited_speed_reg <= res_speed;
            was_clipped_reg   <= res_clipped;
        end
    end

    splim_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .position         (position),
        .speed            (speed),
        .first_of_profile (first_of_profile),
        .q_stat           (q_stat),
        .q_push           (q_push),
        .q_data           (q_wdata)
    );

    splim_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    splim_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .rsp   (sq_rsp)
    );

    splim_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_data      (q_rdata),
        .q_stat      (q_stat),
        .q_pop       (q_pop),
        .sq_req      (sq_req),
        .sq_rsp      (sq_rsp),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_speed   (res_speed),
        .res_clipped (res_clipped)
    );

    a_sqrt_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sq_req.start |-> !sq_rsp.busy)
        else $error("square root restarted while busy");

    a_no_result_during_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        sq_rsp.busy |-> !res_valid)
        else $error("result offered while square root busy");

    a_push_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !q_stat.empty)
        else $error("accepted transaction not queued");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue popped while empty");

endmodule

>>> tb/testbench.sv
// Testbench for the speed profile acceleration limiter: predicts each limited speed and checks it.
`timescale 1ns / 1ps

module testbench;
    import splim_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int NUM_PHASES = 9;
    localparam int PHASE_POINTS = 170;
    localparam int DRAIN_CYCLES = 40;
    localparam int RAND_LIMIT = -1;

    typedef struct packed {
        logic [SPD_W-1:0] spd;
        logic             clipped;
    } limited_pt_t;

    class speed_predictor;
        bit                      mode_dist;
        logic [LIM_W-1:0]        accel_lim;
        logic [LIM_W-1:0]        decel_lim;
        logic [POS_W-1:0]        last_pos;
        logic signed [SPD_W-1:0] last_spd;
        limited_pt_t             expected_speeds[$];
        int                      errors;

        function new();
            mode_dist = 1'b0;
            accel_lim = ACCEL_RESET;
            decel_lim = DECEL_RESET;
            last_pos = '0;
            last_spd = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_LIMIT_BY_DISTANCE: mode_dist = data[0];
                REG_ACCEL_LIMIT:       accel_lim = data;
                REG_DECEL_LIMIT:       decel_lim = data;
                default: ;
            endcase
        endfunction

        // magnitude is scaled and truncated, then the sign of delta is applied
        function longint scale_step(longint lim, longint delta, int sh);
            longint mag;
            longint p;
            mag = (delta < 0) ? -delta : delta;
            p = (lim * mag) >> sh;
            return (delta < 0) ? -p : p;
        endfunction

        function longint unsigned root_floor(longint unsigned r);
            longint unsigned res;
            longint unsigned probe;
            res = 0;
            probe = 64'd1 << 62;
            while (probe > r)
                probe >>= 2;
            while (probe != 0)
            begin
                if (r >= res + probe)
                begin
                    r -= res + probe;
                    res = (res >> 1) + probe;
                end
                else
                    res >>= 1;
                probe >>= 2;
            end
            return res;
        endfunction

        function int clamp_speed(longint v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return int'(v);
        endfunction

        function int root_bound(int prev, longint lim, longint delta, bit add);
            longint sq;
            longint step;
            longint rad;
            longint unsigned root;
            sq = longint'(prev) * longint'(prev);
            step = scale_step(2 * lim, delta, SQ_SHIFT);
            rad = add ? sq + step : sq - step;
            if (rad <= 0)
                return 0;
            root = root_floor(rad);
            return (root > 32767) ? 32767 : int'(root);
        endfunction

        function void take_point(logic [POS_W-1:0] pos, logic signed [SPD_W-1:0] spd,
                                 logic first);
            int          cur;
            int          prev;
            int          res;
            int          b;
            longint      delta;
            limited_pt_t e;
            cur = spd;
            prev = last_spd;
            res = cur;
            delta = longint'({32'd0, pos}) - longint'({32'd0, last_pos});
            if (!first)
            begin
                if (cur > prev)
                begin
                    if (mode_dist)
                        b = root_bound(prev, accel_lim, delta, 1'b1);
                    else
                        b = clamp_speed(prev + scale_step(accel_lim, delta, LIN_SHIFT));
                    res = (b < cur) ? b : cur;
                end
                else if (cur < prev)
                begin
                    if (mode_dist)
                        b = root_bound(prev, decel_lim, delta, 1'b0);
                    else
                        b = clamp_speed(prev - scale_step(decel_lim, delta, LIN_SHIFT));
                    res = (b > cur) ? b : cur;
                end
                else
                    res = (cur < 0) ? 0 : cur;
            end
            last_pos = pos;
            last_spd = spd;
            e.spd = res[SPD_W-1:0];
            e.clipped = (res != cur);
            expected_speeds.insert(expected_speeds.size(), e);
        endfunction

        function void match_output(logic [SPD_W-1:0] spd, logic clipped);
            limited_pt_t e;
            if (expected_speeds.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction, limited_speed %0d was_clipped %0d",
                         $time, $signed(spd), clipped);
                return;
            end
            e = expected_speeds.pop_front();
            if (spd !== e.spd)
            begin
                errors++;
                $display("%0t: limited_speed expected %0d got %0d",
                         $time, $signed(e.spd), $signed(spd));
            end
            if (clipped !== e.clipped)
            begin
                errors++;
                $display("%0t: was_clipped expected %0d got %0d", $time, e.clipped, clipped);
            end
        endfunction

        function int pending();
            return expected_speeds.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [POS_W-1:0]      position = '0;
    logic [SPD_W-1:0]      speed = '0;
    logic                  first_of_profile = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [SPD_W-1:0]      limited_speed;
    logic                  was_clipped;

    int               in_idle_pct = 12;
    int               out_idle_pct = 62;
    bit               hold_req = 1'b0;
    logic [POS_W-1:0] gen_pos = '0;
    int               gen_spd = 0;

    bit phase_dist[NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    int phase_acc[NUM_PHASES]  = '{256, 256, 65535, 1, 65535, 0, 0, RAND_LIMIT, RAND_LIMIT};
    int phase_dec[NUM_PHASES]  = '{256, 256, 1, 65535, 65535, 0, 0, RAND_LIMIT, RAND_LIMIT};

    speed_predictor pred;

    speed_profile_accel_limiter_top u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .position         (position),
        .speed            (speed),
        .first_of_profile (first_of_profile),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .limited_speed    (limited_speed),
        .was_clipped      (was_clipped)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                pred.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                pred.take_point(position, speed, first_of_profile);
            if (out_valid && out_ready)
                pred.match_output(limited_speed, was_clipped);
        end
    end

    // receiver; a requested hold-off keeps out_ready low so the block backs up
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic send_point(input logic [POS_W-1:0] pos, input logic [SPD_W-1:0] spd,
                              input logic f);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        position <= pos;
        speed <= spd;
        first_of_profile <= f;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_limits(input bit use_dist, input logic [LIM_W-1:0] acc,
                              input logic [LIM_W-1:0] dec);
        logic [CFG_DATA_W-1:0] mode_word;
        mode_word = CFG_DATA_W'($urandom);
        mode_word[0] = use_dist;
        write_reg(REG_LIMIT_BY_DISTANCE, mode_word);
        write_reg(REG_ACCEL_LIMIT, acc);
        write_reg(REG_DECEL_LIMIT, dec);
        write_reg(CFG_IDX_W'($urandom_range(REG_DECEL_LIMIT + 1, 255)),
                  CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // stop offering, then wait until every limited speed has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pred.pending() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic run_random(input int count, input bit with_hold);
        int   k;
        int   r;
        logic f;
        for (k = 0; k < count; k++)
        begin
            if (with_hold && k == 40)
                hold_req = 1'b1;
            r = $urandom_range(99);
            if (r < 6)
            begin
                f = 1'b1;
                gen_pos = $urandom_range(0, 32'h00FF_FFFF);
                gen_spd = int'($urandom_range(0, 16000)) - 8000;
            end
            else if (r < 88)
            begin
                f = 1'b0;
                if ($urandom_range(3) == 0)
                    gen_pos += $urandom_range(0, 32'h0004_0000);
                else
                    gen_pos += $urandom_range(0, 32'h0000_4000);
                r = $urandom_range(9);
                if (r >= 7)
                    gen_spd += int'($urandom_range(0, 12000)) - 6000;
                else if (r >= 1)
                    gen_spd += int'($urandom_range(0, 1200)) - 600;
                if (gen_spd > 32767)
                    gen_spd = 32767;
                if (gen_spd < -32768)
                    gen_spd = -32768;
            end
            else
            begin
                f = 1'($urandom_range(1));
                gen_pos = $urandom;
                gen_spd = int'($urandom_range(0, 65535)) - 32768;
            end
            send_point(gen_pos, gen_spd[SPD_W-1:0], f);
        end
    endtask

    initial
    begin
        int p;
        pred = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // time mode at reset limits, no first point after reset
        send_point(32'h0001_0000, 16'h7FFF, 1'b0);
        send_point(32'h0002_0000, 16'h8000, 1'b0);
        send_point(32'h0003_0000, 16'h8000, 1'b0);
        send_point(32'h0003_0000, 16'h8000, 1'b1);
        send_point(32'hFFFF_FFFF, 16'h7FFF, 1'b0);
        send_point(32'h0000_0000, 16'h7FFE, 1'b0);
        send_point(32'h0000_0000, 16'h7FFE, 1'b0);
        send_point(32'h0000_8000, 16'h0000, 1'b0);
        send_point(32'h0000_4000, 16'h0100, 1'b1);
        send_point(32'h0000_2000, 16'h0200, 1'b0);
        wait_drained();

        // distance mode: negative radicand, root saturation, backward delta
        write_reg(8'hFF, 16'h0000);
        set_limits(1'b1, 16'd256, 16'd256);
        @(posedge clk);
        send_point(32'h0000_0000, 16'd1000, 1'b1);
        send_point(32'h0100_0000, 16'hEC78, 1'b0);
        send_point(32'hFFFF_FFFF, 16'h7FFF, 1'b0);
        send_point(32'hFFFF_0000, 16'h7000, 1'b0);
        send_point(32'hFFFF_0100, 16'h7FFF, 1'b0);
        send_point(32'hFFFF_0100, 16'h7FFF, 1'b0);
        send_point(32'hFFFF_0200, 16'h8000, 1'b0);
        send_point(32'hFFFF_0300, 16'h8000, 1'b0);
        wait_drained();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p < 3)
            begin
                in_idle_pct = 12;
                out_idle_pct = 62;
            end
            else if (p < 6)
            begin
                in_idle_pct = 62;
                out_idle_pct = 12;
            end
            else
            begin
                in_idle_pct = 0;
                out_idle_pct = 0;
            end
            set_limits(phase_dist[p],
                       LIM_W'((phase_acc[p] == RAND_LIMIT) ?
                              $urandom_range(1, 65535) : phase_acc[p]),
                       LIM_W'((phase_dec[p] == RAND_LIMIT) ?
                              $urandom_range(1, 65535) : phase_dec[p]));
            @(posedge clk);
            run_random(PHASE_POINTS, (p == 1 || p == 4));
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pred.errors == 0 && pred.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
sv/splim_pkg.sv
sv/splim_front.sv
sv/splim_fifo.sv
sv/splim_sqrt.sv
sv/splim_back.sv
sv/speed_profile_accel_limiter_top.sv
tb/testbench.sv
